// ===== hw/rtl/assert_macros.svh =====
// Assertion macros for the port-level checker of this project.
// Depends on nothing; the including scope must provide clk and arst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/tor_pkg.sv =====
// Package of the text overlay rasterizer: payload types, command type, font ROM.
// Depends on nothing; used by every module of the block.
`timescale 1ns / 1ps

package tor_pkg;

	// Glyph geometry and address width.
	localparam int GLYPH_W    = 6;
	localparam int GLYPH_H    = 8;
	localparam int GLYPH_CNT  = 96;
	localparam int FONT_DEPTH = GLYPH_CNT * GLYPH_H;
	localparam int ADDR_W     = 17;
	localparam int GLYPH_IW   = $clog2(GLYPH_CNT);
	localparam int ROW_W      = $clog2(GLYPH_H);
	localparam int COL_W      = $clog2(GLYPH_W);

	// Character codes.
	localparam logic [7:0] CHAR_NEWLINE = 8'd10;
	localparam logic [7:0] CHAR_FIRST   = 8'd32;
	localparam logic [7:0] CHAR_LAST    = 8'd127;
	localparam logic [7:0] CHAR_SUBST   = 8'd63;

	// Depth of the command queue between front and back end.
	localparam int CMD_DEPTH = 2;

	// One input transaction.
	typedef struct packed {
		logic        new_string;
		logic [7:0]  char_code;
		logic [15:0] start_x;
		logic [15:0] start_y;
		logic [15:0] pixel_color;
	} in_item_t;

	// One result transaction.
	typedef struct packed {
		logic [ADDR_W-1:0] pixel_address;
		logic [15:0]       write_color;
		logic              last_pixel;
	} out_item_t;

	// A character to draw, as the front end hands it to the back end.
	typedef struct packed {
		logic [GLYPH_IW-1:0] glyph;
		logic [ADDR_W-1:0]   px0;
		logic [ADDR_W-1:0]   py0;
		logic [ADDR_W-1:0]   base0;
		logic [15:0]         color;
	} cmd_t;

	// Font rows, eight per glyph, bit 5 is the leftmost column.
	localparam logic [5:0] FONT_ROM [FONT_DEPTH] = '{
		6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
		6'd8,  6'd28, 6'd28, 6'd8,  6'd8,  6'd0,  6'd8,  6'd0,
		6'd20, 6'd20, 6'd20, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
		6'd20, 6'd20, 6'd62, 6'd20, 6'd62, 6'd20, 6'd20, 6'd0,
		6'd8,  6'd30, 6'd32, 6'd28, 6'd2,  6'd60, 6'd24, 6'd0,
		6'd0,  6'd50, 6'd36, 6'd8,  6'd16, 6'd18, 6'd38, 6'd0,
		6'd8,  6'd20, 6'd8,  6'd42, 6'd36, 6'd36, 6'd26, 6'd0,
		6'd8,  6'd8,  6'd4,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
		6'd8,  6'd16, 6'd32, 6'd32, 6'd32, 6'd16, 6'd8,  6'd0,
		6'd16, 6'd8,  6'd4,  6'd4,  6'd4,  6'd8,  6'd16, 6'd0,
		6'd0,  6'd20, 6'd8,  6'd62, 6'd8,  6'd20, 6'd0,  6'd0,
		6'd0,  6'd4,  6'd4,  6'd31, 6'd4,  6'd4,  6'd0,  6'd0,
		6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd8,  6'd8,  6'd16,
		6'd0,  6'd0,  6'd0,  6'd30, 6'd0,  6'd0,  6'd0,  6'd0,
		6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd8,  6'd8,  6'd0,
		6'd0,  6'd1,  6'd2,  6'd4,  6'd8,  6'd16, 6'd32, 6'd0,
		6'd28, 6'd34, 6'd38, 6'd42, 6'd50, 6'd50, 6'd28, 6'd0,
		6'd8,  6'd24, 6'd40, 6'd8,  6'd8,  6'd8,  6'd62, 6'd0,
		6'd28, 6'd34, 6'd2,  6'd12, 6'd24, 6'd34, 6'd62, 6'd0,
		6'd28, 6'd34, 6'd2,  6'd12, 6'd2,  6'd34, 6'd28, 6'd0,
		6'd4,  6'd12, 6'd20, 6'd36, 6'd62, 6'd4,  6'd14, 6'd0,
		6'd62, 6'd32, 6'd32, 6'd60, 6'd2,  6'd34, 6'd28, 6'd0,
		6'd12, 6'd16, 6'd32, 6'd60, 6'd34, 6'd34, 6'd28, 6'd0,
		6'd62, 6'd34, 6'd4,  6'd8,  6'd16, 6'd16, 6'd16, 6'd0,
		6'd28, 6'd34, 6'd34, 6'd28, 6'd34, 6'd34, 6'd28, 6'd0,
		6'd28, 6'd34, 6'd34, 6'd30, 6'd2,  6'd2,  6'd28, 6'd0,
		6'd0,  6'd8,  6'd8,  6'd0,  6'd0,  6'd8,  6'd8,  6'd0,
		6'd0,  6'd8,  6'd8,  6'd0,  6'd0,  6'd8,  6'd8,  6'd16,
		6'd4,  6'd8,  6'd16, 6'd32, 6'd16, 6'd8,  6'd4,  6'd0,
		6'd0,  6'd0,  6'd62, 6'd0,  6'd0,  6'd62, 6'd0,  6'd0,
		6'd16, 6'd8,  6'd4,  6'd2,  6'd4,  6'd8,  6'd16, 6'd0,
		6'd28, 6'd34, 6'd2,  6'd4,  6'd8,  6'd0,  6'd8,  6'd0,
		6'd28, 6'd34, 6'd46, 6'd42, 6'd46, 6'd32, 6'd28, 6'd0,
		6'd8,  6'd20, 6'd34, 6'd34, 6'd62, 6'd34, 6'd34, 6'd0,
		6'd60, 6'd18, 6'd18, 6'd28, 6'd18, 6'd18, 6'd60, 6'd0,
		6'd12, 6'd18, 6'd32, 6'd32, 6'd32, 6'd18, 6'd12, 6'd0,
		6'd60, 6'd18, 6'd18, 6'd18, 6'd18, 6'd18, 6'd60, 6'd0,
		6'd62, 6'd18, 6'd16, 6'd28, 6'd16, 6'd18, 6'd62, 6'd0,
		6'd62, 6'd18, 6'd16, 6'd28, 6'd16, 6'd16, 6'd56, 6'd0,
		6'd12, 6'd18, 6'd32, 6'd32, 6'd38, 6'd18, 6'd14, 6'd0,
		6'd34, 6'd34, 6'd34, 6'd62, 6'd34, 6'd34, 6'd34, 6'd0,
		6'd28, 6'd8,  6'd8,  6'd8,  6'd8,  6'd8,  6'd28, 6'd0,
		6'd14, 6'd4,  6'd4,  6'd4,  6'd36, 6'd36, 6'd24, 6'd0,
		6'd50, 6'd20, 6'd20, 6'd24, 6'd20, 6'd20, 6'd51, 6'd0,
		6'd56, 6'd16, 6'd16, 6'd16, 6'd16, 6'd18, 6'd62, 6'd0,
		6'd34, 6'd54, 6'd42, 6'd42, 6'd34, 6'd34, 6'd34, 6'd0,
		6'd34, 6'd50, 6'd42, 6'd38, 6'd34, 6'd34, 6'd34, 6'd0,
		6'd28, 6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd28, 6'd0,
		6'd60, 6'd18, 6'd18, 6'd28, 6'd16, 6'd16, 6'd56, 6'd0,
		6'd28, 6'd34, 6'd34, 6'd34, 6'd34, 6'd42, 6'd28, 6'd3,
		6'd60, 6'd18, 6'd18, 6'd28, 6'd24, 6'd20, 6'd50, 6'd0,
		6'd28, 6'd34, 6'd32, 6'd28, 6'd2,  6'd34, 6'd28, 6'd0,
		6'd62, 6'd42, 6'd8,  6'd8,  6'd8,  6'd8,  6'd28, 6'd0,
		6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd28, 6'd0,
		6'd34, 6'd34, 6'd34, 6'd34, 6'd34, 6'd20, 6'd8,  6'd0,
		6'd34, 6'd34, 6'd34, 6'd42, 6'd42, 6'd42, 6'd20, 6'd0,
		6'd34, 6'd20, 6'd20, 6'd8,  6'd20, 6'd20, 6'd34, 6'd0,
		6'd34, 6'd34, 6'd20, 6'd8,  6'd8,  6'd8,  6'd28, 6'd0,
		6'd62, 6'd34, 6'd4,  6'd8,  6'd16, 6'd34, 6'd62, 6'd0,
		6'd56, 6'd32, 6'd32, 6'd32, 6'd32, 6'd32, 6'd56, 6'd0,
		6'd32, 6'd32, 6'd16, 6'd8,  6'd4,  6'd2,  6'd1,  6'd0,
		6'd56, 6'd8,  6'd8,  6'd8,  6'd8,  6'd8,  6'd56, 6'd0,
		6'd8,  6'd20, 6'd34, 6'd34, 6'd0,  6'd0,  6'd0,  6'd0,
		6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd63,
		6'd8,  6'd8,  6'd4,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
		6'd0,  6'd0,  6'd28, 6'd2,  6'd30, 6'd34, 6'd31, 6'd0,
		6'd48, 6'd16, 6'd16, 6'd20, 6'd26, 6'd18, 6'd44, 6'd0,
		6'd0,  6'd0,  6'd28, 6'd34, 6'd32, 6'd34, 6'd28, 6'd0,
		6'd6,  6'd2,  6'd2,  6'd26, 6'd38, 6'd38, 6'd27, 6'd0,
		6'd0,  6'd0,  6'd28, 6'd34, 6'd62, 6'd32, 6'd28, 6'd0,
		6'd12, 6'd18, 6'd16, 6'd56, 6'd16, 6'd16, 6'd56, 6'd0,
		6'd0,  6'd0,  6'd26, 6'd34, 6'd34, 6'd30, 6'd2,  6'd60,
		6'd48, 6'd16, 6'd20, 6'd26, 6'd18, 6'd18, 6'd50, 6'd0,
		6'd8,  6'd0,  6'd24, 6'd8,  6'd8,  6'd8,  6'd28, 6'd0,
		6'd2,  6'd0,  6'd6,  6'd2,  6'd2,  6'd34, 6'd34, 6'd28,
		6'd48, 6'd16, 6'd18, 6'd20, 6'd24, 6'd20, 6'd18, 6'd0,
		6'd24, 6'd8,  6'd8,  6'd8,  6'd8,  6'd8,  6'd28, 6'd0,
		6'd0,  6'd0,  6'd52, 6'd42, 6'd42, 6'd42, 6'd42, 6'd0,
		6'd0,  6'd0,  6'd44, 6'd50, 6'd34, 6'd34, 6'd34, 6'd0,
		6'd0,  6'd0,  6'd28, 6'd34, 6'd34, 6'd34, 6'd28, 6'd0,
		6'd0,  6'd0,  6'd60, 6'd18, 6'd18, 6'd28, 6'd16, 6'd56,
		6'd0,  6'd0,  6'd26, 6'd36, 6'd36, 6'd28, 6'd4,  6'd14,
		6'd0,  6'd0,  6'd54, 6'd26, 6'd16, 6'd16, 6'd56, 6'd0,
		6'd0,  6'd0,  6'd30, 6'd32, 6'd28, 6'd2,  6'd60, 6'd0,
		6'd16, 6'd16, 6'd60, 6'd16, 6'd16, 6'd18, 6'd12, 6'd0,
		6'd0,  6'd0,  6'd34, 6'd34, 6'd34, 6'd38, 6'd26, 6'd0,
		6'd0,  6'd0,  6'd34, 6'd34, 6'd34, 6'd20, 6'd8,  6'd0,
		6'd0,  6'd0,  6'd34, 6'd42, 6'd42, 6'd42, 6'd20, 6'd0,
		6'd0,  6'd0,  6'd34, 6'd20, 6'd8,  6'd20, 6'd34, 6'd0,
		6'd0,  6'd0,  6'd34, 6'd34, 6'd34, 6'd30, 6'd2,  6'd60,
		6'd0,  6'd0,  6'd62, 6'd4,  6'd8,  6'd16, 6'd62, 6'd0,
		6'd6,  6'd8,  6'd8,  6'd48, 6'd8,  6'd8,  6'd6,  6'd0,
		6'd8,  6'd8,  6'd8,  6'd0,  6'd8,  6'd8,  6'd8,  6'd0,
		6'd48, 6'd8,  6'd8,  6'd6,  6'd8,  6'd8,  6'd48, 6'd0,
		6'd18, 6'd44, 6'd0,  6'd0,  6'd0,  6'd0,  6'd0,  6'd0,
		6'd0,  6'd8,  6'd20, 6'd34, 6'd34, 6'd34, 6'd62, 6'd0
	};

endpackage

// ===== hw/rtl/text_overlay_rasterizer.sv =====
// Top level of the text overlay rasterizer: front end, command queue and back end.
// Depends on tor_pkg, tor_front, tor_cmd_queue and tor_back.
//
//   Channel   Handshake           Payload                      Direction
//   item      push / full         tor_pkg::in_item_t           into the block
//   result    empty / pop         tor_pkg::out_item_t          out of the block
//
// A newline is absorbed by the front end and gives no result.
// A drawn character passes the back end in steps: a load, a scan of the 48 glyph
// positions (one font row read per row), and a flush of the last pixel.
// The front end runs ahead by up to two characters through the command queue.
// Waiting results stall the scan only when a second pixel needs the output register.
// Reset is asynchronous and active low; it clears the cursor to the origin.
`timescale 1ns / 1ps

module text_overlay_rasterizer #(
	parameter int FRAME_STRIDE = 320,
	parameter int FRAME_MAX_X  = 316,
	parameter int FRAME_MAX_Y  = 237
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  tor_pkg::in_item_t  item,
	output logic               empty,
	input  logic               pop,
	output tor_pkg::out_item_t result
);

	logic          q_full;
	logic          q_empty;
	logic          cmd_wr;
	logic          cmd_pop;
	tor_pkg::cmd_t cmd_in;
	tor_pkg::cmd_t cmd_out;

	tor_front #(
		.FRAME_STRIDE(FRAME_STRIDE)
	) u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.q_full (q_full),
		.cmd_wr (cmd_wr),
		.cmd    (cmd_in)
	);

	tor_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (cmd_wr),
		.wr_data (cmd_in),
		.full    (q_full),
		.rd      (cmd_pop),
		.rd_data (cmd_out),
		.empty   (q_empty)
	);

	tor_back #(
		.FRAME_STRIDE(FRAME_STRIDE),
		.FRAME_MAX_X (FRAME_MAX_X),
		.FRAME_MAX_Y (FRAME_MAX_Y)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd_out),
		.cmd_valid (!q_empty),
		.cmd_pop   (cmd_pop),
		.empty     (empty),
		.pop       (pop),
		.result    (result)
	);

endmodule

// ===== hw/rtl/tor_front.sv =====
// Front end: accepts characters, keeps the cursor and turns drawn characters into commands.
// Depends on tor_pkg.
`timescale 1ns / 1ps

module tor_front #(
	parameter int FRAME_STRIDE = 320
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	output logic             full,
	input  tor_pkg::in_item_t item,
	input  logic             q_full,
	output logic             cmd_wr,
	output tor_pkg::cmd_t    cmd
);

	localparam logic [tor_pkg::ADDR_W-1:0] STRIDE_A = tor_pkg::ADDR_W'(FRAME_STRIDE);

	logic [15:0] cursor_x_q;
	logic [15:0] cursor_y_q;
	logic [15:0] line_start_q;

	logic        accept;
	logic        is_newline;
	logic        printable;
	logic [15:0] cx_eff;
	logic [15:0] cy_eff;
	logic [15:0] ls_eff;
	logic [7:0]  glyph_code;
	logic [tor_pkg::ADDR_W-1:0] py0;

	assign full       = q_full;
	assign accept     = push && !q_full;
	assign is_newline = (item.char_code == tor_pkg::CHAR_NEWLINE);

	// A new string reloads the cursor before the character is handled.
	assign cx_eff = item.new_string ? item.start_x : cursor_x_q;
	assign cy_eff = item.new_string ? item.start_y : cursor_y_q;
	assign ls_eff = item.new_string ? item.start_x : line_start_q;

	// Unprintable codes are drawn with the question mark glyph.
	assign printable  = (item.char_code >= tor_pkg::CHAR_FIRST) &&
		(item.char_code <= tor_pkg::CHAR_LAST);
	assign glyph_code = printable ? item.char_code : tor_pkg::CHAR_SUBST;

	// Command for the back end: first pixel column, first pixel row and its row base.
	assign py0 = {1'b0, cy_eff} + tor_pkg::ADDR_W'(1);
	always_comb begin
		cmd.glyph = tor_pkg::GLYPH_IW'(glyph_code - tor_pkg::CHAR_FIRST);
		cmd.px0   = {1'b0, cx_eff} + tor_pkg::ADDR_W'(4);
		cmd.py0   = py0;
		cmd.base0 = tor_pkg::ADDR_W'(py0 * STRIDE_A);
		cmd.color = item.pixel_color;
	end

	assign cmd_wr = accept && !is_newline;

	// Cursor state advances once per accepted transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q   <= '0;
			cursor_y_q   <= '0;
			line_start_q <= '0;
		end else if (accept) begin
			line_start_q <= ls_eff;
			if (is_newline) begin
				cursor_x_q <= ls_eff;
				cursor_y_q <= cy_eff + 16'(tor_pkg::GLYPH_H);
			end else begin
				cursor_x_q <= cx_eff + 16'(tor_pkg::GLYPH_W);
				cursor_y_q <= cy_eff;
			end
		end
	end

endmodule

// ===== hw/rtl/tor_cmd_queue.sv =====
// Short command queue between the front end and the back end.
// Depends on tor_pkg.
`timescale 1ns / 1ps

module tor_cmd_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr,
	input  tor_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd,
	output tor_pkg::cmd_t rd_data,
	output logic          empty
);

	localparam int PTR_W = $clog2(tor_pkg::CMD_DEPTH);
	localparam int CNT_W = $clog2(tor_pkg::CMD_DEPTH + 1);

	tor_pkg::cmd_t    entry_q [tor_pkg::CMD_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_wr;
	logic             do_rd;

	assign full    = (count_q == CNT_W'(tor_pkg::CMD_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !empty;
	assign rd_data = entry_q[rd_ptr_q];

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(tor_pkg::CMD_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(tor_pkg::CMD_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_wr) begin
			entry_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule

// ===== hw/rtl/tor_back.sv =====
// Back end: scans one glyph position per cycle if unstalled, emits visible pixels.
// Depends on tor_pkg.
`timescale 1ns / 1ps

module tor_back #(
	parameter int FRAME_STRIDE = 320,
	parameter int FRAME_MAX_X  = 316,
	parameter int FRAME_MAX_Y  = 237
) (
	input  logic               clk,
	input  logic               arst_n,
	input  tor_pkg::cmd_t      cmd,
	input  logic               cmd_valid,
	output logic               cmd_pop,
	output logic               empty,
	input  logic               pop,
	output tor_pkg::out_item_t result
);

	localparam int AW = tor_pkg::ADDR_W;
	localparam logic [AW-1:0] STRIDE_A = AW'(FRAME_STRIDE);
	localparam logic [AW-1:0] MAX_X_A  = AW'(FRAME_MAX_X);
	localparam logic [AW-1:0] MAX_Y_A  = AW'(FRAME_MAX_Y);
	localparam logic [tor_pkg::COL_W-1:0] COL_LAST = tor_pkg::COL_W'(tor_pkg::GLYPH_W - 1);
	localparam logic [tor_pkg::ROW_W-1:0] ROW_LAST = tor_pkg::ROW_W'(tor_pkg::GLYPH_H - 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_SCAN  = 2'd1;
	localparam logic [1:0] ST_FLUSH = 2'd2;

	logic [1:0]                    state_q;
	logic [tor_pkg::GLYPH_IW-1:0]  glyph_q;
	logic [tor_pkg::ROW_W-1:0]     row_q;
	logic [tor_pkg::COL_W-1:0]     col_q;
	logic [AW-1:0]                 px0_q;
	logic [AW-1:0]                 px_q;
	logic [AW-1:0]                 py_q;
	logic [AW-1:0]                 base_q;
	logic [15:0]                   color_q;
	logic [5:0]                    bits_q;
	logic                          pend_valid_q;
	tor_pkg::out_item_t            pend_q;
	logic                          out_valid_q;
	tor_pkg::out_item_t            out_q;

	logic                          load;
	logic                          slot_free;
	logic                          bit_set;
	logic                          hit;
	logic                          stall;
	logic                          advance;
	logic                          row_end;
	logic                          char_end;
	logic                          flush_move;
	logic                          flush_go;
	logic                          move;
	logic [AW:0]                   addr_sum;
	logic [AW:0]                   px_inc;
	logic [AW:0]                   base_inc;
	logic [tor_pkg::GLYPH_IW-1:0]  glyph_d;
	logic [tor_pkg::ROW_W-1:0]     row_d;

	assign load      = (state_q == ST_IDLE) && cmd_valid;
	assign cmd_pop   = load;
	assign slot_free = !out_valid_q || pop;

	// Pixel test at the current scan position.
	assign bit_set  = bits_q[COL_LAST - col_q];
	assign hit      = (state_q == ST_SCAN) && bit_set && (px_q <= MAX_X_A) && (py_q <= MAX_Y_A);
	assign stall    = hit && pend_valid_q && !slot_free;
	assign advance  = (state_q == ST_SCAN) && !stall;
	assign row_end  = (col_q == COL_LAST);
	assign char_end = row_end && (row_q == ROW_LAST);

	// The last found pixel waits in the pending slot until the next one, or the
	// end of the character, tells whether it closes the character.
	assign flush_move = (state_q == ST_FLUSH) && pend_valid_q && slot_free;
	assign flush_go   = (state_q == ST_FLUSH) && (!pend_valid_q || slot_free);
	assign move       = (hit && pend_valid_q && slot_free) || flush_move;

	assign addr_sum = {1'b0, base_q} + {1'b0, px_q};
	assign px_inc   = {1'b0, px_q} + (AW + 1)'(1);
	assign base_inc = {1'b0, base_q} + {1'b0, STRIDE_A};

	// Font ROM read address follows the next scan row.
	assign glyph_d = load ? cmd.glyph : glyph_q;
	always_comb begin
		if (load) begin
			row_d = '0;
		end else if (advance && row_end) begin
			row_d = row_q + 1'b1;
		end else begin
			row_d = row_q;
		end
	end

	always_ff @(posedge clk) begin
		bits_q <= tor_pkg::FONT_ROM[{glyph_d, row_d}];
	end

	// Sequencer and scan counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			row_q   <= '0;
			col_q   <= '0;
		end else begin
			row_q <= row_d;
			unique case (state_q)
				ST_IDLE: begin
					if (load) begin
						col_q   <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (advance) begin
						col_q <= row_end ? '0 : col_q + 1'b1;
						if (char_end) begin
							state_q <= ST_FLUSH;
						end
					end
				end
				ST_FLUSH: begin
					if (flush_go) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Scan coordinates and row base.
	always_ff @(posedge clk) begin
		if (load) begin
			glyph_q <= cmd.glyph;
			px0_q   <= cmd.px0;
			px_q    <= cmd.px0;
			py_q    <= cmd.py0;
			base_q  <= cmd.base0;
			color_q <= cmd.color;
		end else if (advance) begin
			if (row_end) begin
				px_q   <= px0_q;
				py_q   <= py_q + 1'b1;
				base_q <= base_inc[AW-1:0];
			end else begin
				px_q <= px_inc[AW-1:0];
			end
		end
	end

	// Pending pixel and output register valid flags.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (hit && !stall) begin
				pend_valid_q <= 1'b1;
			end else if (flush_move) begin
				pend_valid_q <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pending pixel and output register contents.
	always_ff @(posedge clk) begin
		if (hit && !stall) begin
			pend_q.pixel_address <= addr_sum[AW-1:0];
			pend_q.write_color   <= color_q;
			pend_q.last_pixel    <= 1'b0;
		end
		if (move) begin
			out_q.pixel_address <= pend_q.pixel_address;
			out_q.write_color   <= pend_q.write_color;
			out_q.last_pixel    <= (state_q == ST_FLUSH);
		end
	end

	assign empty  = !out_valid_q;
	assign result = out_q;

endmodule

// ===== hw/rtl/tor_checker.sv =====
// Port-level checker for the text overlay rasterizer, attached by bind.
// Depends on tor_pkg, assert_macros.svh and text_overlay_rasterizer.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tor_checker #(
	parameter int FRAME_STRIDE = 320,
	parameter int FRAME_MAX_X  = 316,
	parameter int FRAME_MAX_Y  = 237
) (
	input logic               clk,
	input logic               arst_n,
	input logic               push,
	input logic               full,
	input tor_pkg::in_item_t  item,
	input logic               empty,
	input logic               pop,
	input tor_pkg::out_item_t result
);

	// One past the top visible pixel address, capped by the address width.
	localparam longint AREA = longint'(FRAME_MAX_Y) * FRAME_STRIDE + FRAME_MAX_X + 1;
	localparam longint SPAN = longint'(1) << tor_pkg::ADDR_W;
	localparam longint ADDR_LIMIT = (AREA < SPAN) ? AREA : SPAN;

	logic seen_q;

	// Remembers whether any transaction has entered the block yet.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= 1'b0;
		end else if (push && !full) begin
			seen_q <= 1'b1;
		end
	end

	`ASSERT_NEXT(a_result_hold, !empty && !pop, !empty && $stable(result), "result changed while waiting")
	`ASSERT_IMPL(a_addr_range, !empty, longint'(result.pixel_address) < ADDR_LIMIT, "pixel outside frame")
	`ASSERT_IMPL(a_no_early_result, !seen_q, empty, "result shown before any input transaction")

endmodule

bind text_overlay_rasterizer tor_checker #(
	.FRAME_STRIDE(FRAME_STRIDE),
	.FRAME_MAX_X (FRAME_MAX_X),
	.FRAME_MAX_Y (FRAME_MAX_Y)
) u_tor_checker (.*);

// ===== bench/glyph_write_checker.sv =====
// Checker of the text overlay rasterizer: predicts the pixel writes of every
// accepted character and compares them with the result transactions.
// Depends on tor_pkg for the payload types, character codes and font rows.
`timescale 1ns / 1ps

module glyph_write_checker #(
	parameter int FRAME_STRIDE = 320,
	parameter int FRAME_MAX_X  = 316,
	parameter int FRAME_MAX_Y  = 237
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  tor_pkg::in_item_t  item,
	input  logic               empty,
	input  logic               pop,
	input  tor_pkg::out_item_t result,
	output int                 fail_count,
	output int                 pending_writes
);
	import tor_pkg::*;

	// Cursor as the block should hold it.
	logic [15:0] pen_x;
	logic [15:0] pen_y;
	logic [15:0] margin_x;

	// Pixel writes that are predicted but not yet seen, oldest first.
	out_item_t expected_writes[$];

	initial begin
		fail_count     = 0;
		pending_writes = 0;
	end

	task automatic report_mismatch(input string what, input int unsigned got,
			input int unsigned want);
		$display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
		fail_count++;
	endtask

	// Works out the writes of one character and moves the cursor.
	task automatic plot_glyph(input in_item_t ch);
		logic [7:0]  code;
		int unsigned glyph_base;
		int unsigned px;
		int unsigned py;
		logic [5:0]  bits;
		out_item_t   wr;
		out_item_t   strokes[$];
		code = ch.char_code;
		if (ch.new_string) begin
			pen_x    = ch.start_x;
			pen_y    = ch.start_y;
			margin_x = ch.start_x;
		end
		if (code == CHAR_NEWLINE) begin
			pen_x = margin_x;
			pen_y = pen_y + 16'd8;
		end else begin
			// Anything outside the printable range is drawn as a question mark.
			if (code < CHAR_FIRST || code > CHAR_LAST)
				code = CHAR_SUBST;
			glyph_base = (int'(code) - int'(CHAR_FIRST)) * GLYPH_H;
			for (int r = 0; r < GLYPH_H; r++) begin
				bits = FONT_ROM[glyph_base + r];
				for (int c = 0; c < GLYPH_W; c++) begin
					if (bits[5 - c]) begin
						px = int'(pen_x) + c + 4;
						py = int'(pen_y) + r + 1;
						if (px <= FRAME_MAX_X && py <= FRAME_MAX_Y) begin
							wr.pixel_address = ADDR_W'(py * FRAME_STRIDE + px);
							wr.write_color   = ch.pixel_color;
							wr.last_pixel    = 1'b0;
							strokes.push_back(wr);
						end
					end
				end
			end
			// Only the final write of a character carries the last flag.
			if (strokes.size() > 0)
				strokes[strokes.size() - 1].last_pixel = 1'b1;
			foreach (strokes[i])
				expected_writes.push_back(strokes[i]);
			pen_x = pen_x + 16'd6;
		end
	endtask

	// Watch both channels on the rising edge.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			pen_x    = '0;
			pen_y    = '0;
			margin_x = '0;
			expected_writes.delete();
		end else begin
			if (push && !full)
				plot_glyph(item);
			if (pop && !empty) begin
				if (expected_writes.size() == 0) begin
					report_mismatch("unexpected write at address", result.pixel_address, 0);
				end else begin
					want = expected_writes.pop_front();
					if (result.pixel_address !== want.pixel_address)
						report_mismatch("pixel_address", result.pixel_address,
							want.pixel_address);
					if (result.write_color !== want.write_color)
						report_mismatch("write_color", result.write_color, want.write_color);
					if (result.last_pixel !== want.last_pixel)
						report_mismatch("last_pixel", result.last_pixel, want.last_pixel);
				end
			end
		end
		pending_writes = expected_writes.size();
	end

endmodule

// ===== bench/testbench.sv =====
// Top of the text overlay rasterizer bench: clock, reset, character stimulus
// with random idling on both channels, and the final verdict.
// Depends on tor_pkg, text_overlay_rasterizer and glyph_write_checker.
`timescale 1ns / 1ps

module testbench;
	import tor_pkg::*;

	logic      clk    = 1'b0;
	logic      arst_n = 1'b0;
	logic      push   = 1'b0;
	logic      full;
	in_item_t  item   = '0;
	logic      empty;
	logic      pop    = 1'b0;
	out_item_t result;

	int fail_count;
	int pending_writes;
	int chars_sent;
	bit sender_gaps   = 1'b1;
	bit receiver_gaps = 1'b1;
	bit drained       = 1'b0;

	always #10 clk = ~clk;

	text_overlay_rasterizer u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.item   (item),
		.empty  (empty),
		.pop    (pop),
		.result (result)
	);

	glyph_write_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.push           (push),
		.full           (full),
		.item           (item),
		.empty          (empty),
		.pop            (pop),
		.result         (result),
		.fail_count     (fail_count),
		.pending_writes (pending_writes)
	);

	// Offers one character and holds it until the block takes the transaction.
	task automatic send_char(input logic fresh, input logic [7:0] code,
			input logic [15:0] sx, input logic [15:0] sy, input logic [15:0] color);
		@(negedge clk);
		if (sender_gaps && $urandom_range(0, 3) == 0) begin
			push = 1'b0;
			repeat ($urandom_range(1, 10)) @(negedge clk);
		end
		item.new_string  = fresh;
		item.char_code   = code;
		item.start_x     = sx;
		item.start_y     = sy;
		item.pixel_color = color;
		push = 1'b1;
		@(posedge clk);
		while (full)
			@(posedge clk);
		chars_sent++;
	endtask

	// Mostly printable text, with newlines, unprintable codes and raw bytes mixed in.
	function automatic logic [7:0] pick_code();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 70)
			return 8'($urandom_range(CHAR_FIRST, CHAR_LAST));
		else if (roll < 82)
			return CHAR_NEWLINE;
		else if (roll < 91)
			return 8'($urandom_range(0, 31));
		else
			return 8'($urandom);
	endfunction

	// Sends one string: a fresh start position, then a run of characters.
	task automatic send_string();
		logic [15:0] sx;
		logic [15:0] sy;
		int unsigned roll;
		int unsigned len;
		roll = $urandom_range(0, 9);
		sx   = 16'($urandom_range(0, 316));
		sy   = 16'($urandom_range(0, 237));
		if (roll == 0)
			sx = 16'($urandom_range(290, 330));
		else if (roll == 1)
			sy = 16'($urandom_range(220, 245));
		else if (roll == 2) begin
			sx = 16'($urandom);
			sy = 16'($urandom);
		end
		len = $urandom_range(1, 12);
		send_char(1'b1, pick_code(), sx, sy, 16'($urandom));
		for (int i = 1; i < len; i++)
			send_char(1'b0, pick_code(), 16'($urandom), 16'($urandom), 16'($urandom));
	endtask

	// Result side: takes writes, stalling in bursts while idling is on.
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (receiver_gaps && $urandom_range(0, 5) == 0) begin
				pop = 1'b0;
				repeat ($urandom_range(0, 9)) @(negedge clk);
			end else begin
				pop = 1'b1;
			end
		end
	end

	// Stimulus and verdict.
	initial begin
		chars_sent = 0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;

		// Directed part: first character from the reset cursor, edge codes, clipping,
		// cursor wrap in both directions and the largest reachable address.
		send_char(1'b0, "A", 16'h0000, 16'h0000, 16'hFFFF);
		send_char(1'b1, " ", 16'h0000, 16'h0000, 16'h0000);
		send_char(1'b0, CHAR_LAST, 16'hFFFF, 16'hFFFF, 16'h0000);
		send_char(1'b0, 8'd0, 16'h0000, 16'h0000, 16'h8421);
		send_char(1'b0, 8'd31, 16'h0000, 16'h0000, 16'h5AA5);
		send_char(1'b0, 8'd128, 16'h0000, 16'h0000, 16'hA55A);
		send_char(1'b0, 8'd255, 16'h0000, 16'h0000, 16'h1234);
		send_char(1'b0, CHAR_NEWLINE, 16'h0000, 16'h0000, 16'h0000);
		send_char(1'b0, "W", 16'h0000, 16'h0000, 16'hF00F);
		send_char(1'b1, "M", 16'd310, 16'd20, 16'h0F0F);
		send_char(1'b0, "_", 16'h0000, 16'h0000, 16'h00FF);
		send_char(1'b1, "|", 16'd100, 16'd232, 16'hFF00);
		send_char(1'b1, CHAR_NEWLINE, 16'd50, 16'hFFFF, 16'h0000);
		send_char(1'b0, "g", 16'h0000, 16'h0000, 16'h7FFF);
		send_char(1'b1, "#", 16'hFFFF, 16'd10, 16'h3C3C);
		send_char(1'b0, "H", 16'h0000, 16'h0000, 16'hC3C3);
		send_char(1'b1, "_", 16'd307, 16'd229, 16'hFFFF);
		send_char(1'b1, "@", 16'h0000, 16'h0000, 16'h7FFF);
		send_char(1'b0, "Q", 16'hFFFF, 16'hFFFF, 16'h8000);
		send_char(1'b0, "~", 16'h0000, 16'h0000, 16'h0001);
		send_char(1'b1, "y", 16'd200, 16'd230, 16'hBEEF);

		// Random strings, plus a little noise of lone random transactions.
		while (chars_sent < 330) begin
			if (!drained && chars_sent >= 150) begin
				// Hold off until the block has drained every write.
				@(negedge clk);
				push = 1'b0;
				wait (pending_writes == 0);
				drained = 1'b1;
			end
			if (chars_sent >= 270) begin
				sender_gaps   = 1'b0;
				receiver_gaps = 1'b0;
			end else if (chars_sent >= 100 && chars_sent < 130) begin
				sender_gaps   = 1'b0;
			end else begin
				sender_gaps   = 1'b1;
			end
			if ($urandom_range(0, 9) == 0)
				send_char(1'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom));
			else
				send_string();
		end

		@(negedge clk);
		push = 1'b0;
		wait (pending_writes == 0);
		repeat (60) @(posedge clk);
		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

	// Watchdog.
	initial begin
		#20_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/tor_pkg.sv
hw/rtl/tor_front.sv
hw/rtl/tor_cmd_queue.sv
hw/rtl/tor_back.sv
hw/rtl/text_overlay_rasterizer.sv
hw/rtl/tor_checker.sv
bench/glyph_write_checker.sv
bench/testbench.sv
